/* hw/rtl/gsm_pkg.sv */
// Shared types and constants for the grouped softmax core.
// No dependencies; used by every module under hw/rtl.
package gsm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LOGIT_W    = 16;
    localparam int EXP_W      = 16;
    localparam int SUM_W      = 24;
    localparam int PROB_W     = 17;
    localparam int CHAN_W     = 6;
    localparam int NUM_W      = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_BASE = 3'd1;

    localparam logic [16:0]      LOG2E_Q16  = 17'd94548;
    localparam logic [EXP_W-1:0] EXP_ONE    = 16'd32768;
    localparam logic [PROB_W-1:0] PROB_ONE  = 17'd65536;
    localparam logic [3:0]       EXP_STEPS  = 4'd12;

    typedef struct packed {
        logic load_we;
        logic load_end;
        logic cnt_clr;
        logic cnt_inc;
        logic max_upd;
        logic exp_start;
        logic exp_wr;
        logic div_start;
        logic out_load;
    } gsm_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic exp_done;
        logic div_done;
    } gsm_status_t;

    // round(65536 * 2^(-2^-(k+1))) for fraction bit k, k = 0 is the half bit
    function automatic logic [15:0] pow_step(input logic [3:0] k);
        logic [15:0] c;
        unique case (k)
            4'd0:    c = 16'd46341;
            4'd1:    c = 16'd55109;
            4'd2:    c = 16'd60097;
            4'd3:    c = 16'd62757;
            4'd4:    c = 16'd64132;
            4'd5:    c = 16'd64830;
            4'd6:    c = 16'd65182;
            4'd7:    c = 16'd65359;
            4'd8:    c = 16'd65447;
            4'd9:    c = 16'd65492;
            4'd10:   c = 16'd65514;
            4'd11:   c = 16'd65525;
            default: c = 16'd0;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/grouped_softmax_core.sv */
// Grouped softmax: logits load at one per cycle; after the last one, the
// vector is processed in three passes: max (a read and an update per channel),
// exp (a 12-step exp iteration per channel) and divide plus emit (a 32-bit
// serial divider per channel, each result held until the output takes it).
// Synchronous active-low reset returns to load.
module grouped_softmax_core #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_GROUPS   = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [gsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // logit requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] logit
    input  logic                              s_tlast,   // vector_end
    // probability requests
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gsm_pkg::OUT_DATA_W-1:0]    m_tdata,   // [16:0] probability, [22:17] channel_index
    output logic                              m_tlast    // run_last
);
    gsm_pkg::gsm_cmd_t    cmd;
    gsm_pkg::gsm_status_t status;

    // controller walks the passes; datapath owns all storage and arithmetic
    gsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    gsm_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_GROUPS   (MAX_GROUPS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .logit_in  (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // input side and output side never open together
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input and output both active");

    // a vector end closes the input until results drain
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open after vector end");

    // the last result reopens the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("input not reopened after last result");

    // probabilities never exceed one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[16:0] <= 17'd65536)
        else $error("probability above one");
endmodule

/* hw/rtl/gsm_exp.sv */
// Iterative fixed-point exp(-d) unit, one fraction bit per cycle.
// Depends on gsm_pkg.
module gsm_exp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [15:0]                d_in,
    output logic                       done,
    output logic [gsm_pkg::EXP_W-1:0]  e_out
);
    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  step_reg;
    logic [32:0] y_reg;
    logic [16:0] m_reg;
    logic [gsm_pkg::EXP_W-1:0] e_reg;

    logic [11:0] fr;
    logic [8:0]  ip;
    logic [33:0] prod;
    logic [16:0] m_next;
    logic [17:0] round_sum;
    logic [gsm_pkg::EXP_W-1:0] e_next;

    assign fr        = y_reg[23:12];
    assign ip        = y_reg[32:24];
    assign prod      = 34'(m_reg) * 34'(gsm_pkg::pow_step(step_reg)) + 34'd32768;
    assign m_next    = prod[32:16];
    assign round_sum = 18'(m_reg) + (18'd1 << ip[3:0]);
    assign e_next    = (ip >= 9'd16) ? '0 :
                       gsm_pkg::EXP_W'(round_sum >> ({1'b0, ip[3:0]} + 5'd1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == gsm_pkg::EXP_STEPS) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg <= 33'(d_in) * 33'(gsm_pkg::LOG2E_Q16);
            m_reg <= 17'd65536;
        end else if (busy_reg && step_reg != gsm_pkg::EXP_STEPS) begin
            if (fr[4'd11 - step_reg]) begin
                m_reg <= m_next;
            end
        end
        if (busy_reg && step_reg == gsm_pkg::EXP_STEPS) begin
            e_reg <= e_next;
        end
    end

    assign done  = done_reg;
    assign e_out = e_reg;
endmodule

/* hw/rtl/gsm_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on gsm_pkg.
module gsm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [gsm_pkg::NUM_W-1:0]  num,
    input  logic [gsm_pkg::SUM_W-1:0]  den,
    output logic                       done,
    output logic [gsm_pkg::NUM_W-1:0]  quo
);
    localparam int BW = $clog2(gsm_pkg::NUM_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [BW-1:0]               bit_reg;
    logic [gsm_pkg::NUM_W-1:0]   nq_reg;
    logic [gsm_pkg::SUM_W-1:0]   rem_reg;
    logic [gsm_pkg::SUM_W-1:0]   den_reg;

    logic [gsm_pkg::SUM_W:0]     rem_shift;
    logic                        fits;

    assign rem_shift = {rem_reg, nq_reg[gsm_pkg::NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                bit_reg  <= '0;
            end else if (busy_reg) begin
                if (bit_reg == BW'(gsm_pkg::NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                bit_reg <= bit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            nq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            nq_reg  <= {nq_reg[gsm_pkg::NUM_W-2:0], fits};
            rem_reg <= fits ? gsm_pkg::SUM_W'(rem_shift - {1'b0, den_reg})
                            : gsm_pkg::SUM_W'(rem_shift);
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;
endmodule

/* hw/rtl/gsm_dp.sv */
// Datapath: config registers, logit and exp stores, group max and sum,
// exp and divide units, output register. Depends on gsm_pkg, gsm_exp, gsm_div.
module gsm_dp #(
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_GROUPS   = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [gsm_pkg::LOGIT_W-1:0]       logit_in,
    input  gsm_pkg::gsm_cmd_t                 cmd,
    output gsm_pkg::gsm_status_t              status,
    output logic [gsm_pkg::OUT_DATA_W-1:0]    out_data,
    output logic                              out_last
);
    localparam int CW  = $clog2(MAX_CHANNELS);
    localparam int NW  = CW + 1;
    localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    logic [2:0]                       count_reg;
    logic [15:0]                      bounds_reg [MAX_GROUPS];

    logic [gsm_pkg::LOGIT_W-1:0]      logit_mem [MAX_CHANNELS];
    logic [gsm_pkg::EXP_W-1:0]        exp_mem   [MAX_CHANNELS];
    logic [gsm_pkg::LOGIT_W-1:0]      rd_logit_reg;
    logic [gsm_pkg::EXP_W-1:0]        rd_exp_reg;

    logic [NW-1:0]                    load_cnt_reg;
    logic [NW-1:0]                    n_reg;
    logic [CW-1:0]                    cnt_reg;

    logic signed [gsm_pkg::LOGIT_W-1:0] max_reg  [MAX_GROUPS];
    logic [MAX_GROUPS-1:0]            seen_reg;
    logic [gsm_pkg::SUM_W-1:0]        sum_reg  [MAX_GROUPS];

    logic [gsm_pkg::PROB_W-1:0]       prob_reg;
    logic [gsm_pkg::CHAN_W-1:0]       chan_reg;
    logic                             last_reg;

    logic                             own_v;
    logic [GIW-1:0]                   own_idx;
    logic                             room;
    logic signed [16:0]               diff;
    logic                             exp_done;
    logic [gsm_pkg::EXP_W-1:0]        exp_e;
    logic                             div_done;
    logic [gsm_pkg::NUM_W-1:0]        div_q;
    logic [gsm_pkg::NUM_W-1:0]        div_num;
    logic [gsm_pkg::SUM_W-1:0]        own_sum;
    logic [gsm_pkg::PROB_W-1:0]       prob_next;

    // highest-numbered group whose range covers the current channel owns it
    always_comb begin
        own_v   = 1'b0;
        own_idx = '0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            if (3'(g) < count_reg &&
                {1'b0, bounds_reg[g][7:0]} <= 9'(cnt_reg) &&
                9'(cnt_reg) <= {1'b0, bounds_reg[g][15:8]}) begin
                own_v   = 1'b1;
                own_idx = GIW'(g);
            end
        end
    end

    assign room    = load_cnt_reg < NW'(MAX_CHANNELS);
    assign diff    = 17'(max_reg[own_idx]) - 17'($signed(rd_logit_reg));
    assign own_sum = sum_reg[own_idx];
    assign div_num = {rd_exp_reg, 16'd0} + gsm_pkg::NUM_W'(own_sum >> 1);

    assign status.cnt_last = ({1'b0, cnt_reg} == n_reg - 1'b1);
    assign status.exp_done = exp_done;
    assign status.div_done = div_done;

    always_comb begin
        if (!own_v || own_sum == '0 || div_q > gsm_pkg::NUM_W'(gsm_pkg::PROB_ONE)) begin
            prob_next = gsm_pkg::PROB_ONE;
        end else begin
            prob_next = div_q[gsm_pkg::PROB_W-1:0];
        end
    end

    gsm_exp u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.exp_start),
        .d_in    (diff[15:0]),
        .done    (exp_done),
        .e_out   (exp_e)
    );

    gsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (own_sum),
        .done    (div_done),
        .quo     (div_q)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                bounds_reg[g] <= '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == gsm_pkg::REG_GROUP_COUNT) begin
                count_reg <= cfg_wdata[2:0];
            end else if (cfg_index >= gsm_pkg::REG_BOUNDS_BASE &&
                         cfg_index <  gsm_pkg::REG_BOUNDS_BASE + 3'(MAX_GROUPS)) begin
                bounds_reg[GIW'(cfg_index - gsm_pkg::REG_BOUNDS_BASE)] <= cfg_wdata;
            end
        end
    end

    // counters and group state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
            n_reg        <= NW'(1);
            cnt_reg      <= '0;
            seen_reg     <= '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                sum_reg[g] <= '0;
            end
        end else begin
            if (cmd.load_we) begin
                if (cmd.load_end) begin
                    load_cnt_reg <= '0;
                    n_reg        <= load_cnt_reg + NW'(room);
                    seen_reg     <= '0;
                    for (int g = 0; g < MAX_GROUPS; g++) begin
                        sum_reg[g] <= '0;
                    end
                end else if (room) begin
                    load_cnt_reg <= load_cnt_reg + 1'b1;
                end
            end
            if (cmd.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.max_upd && own_v) begin
                seen_reg[own_idx] <= 1'b1;
            end
            if (cmd.exp_wr && own_v) begin
                sum_reg[own_idx] <= sum_reg[own_idx] + gsm_pkg::SUM_W'(exp_e);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.max_upd && own_v &&
            (!seen_reg[own_idx] || $signed(rd_logit_reg) > max_reg[own_idx])) begin
            max_reg[own_idx] <= $signed(rd_logit_reg);
        end
    end

    // stores, registered reads
    always_ff @(posedge aclk) begin
        if (cmd.load_we && room) begin
            logit_mem[load_cnt_reg[CW-1:0]] <= logit_in;
        end
        rd_logit_reg <= logit_mem[cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.exp_wr) begin
            exp_mem[cnt_reg] <= own_v ? exp_e : gsm_pkg::EXP_ONE;
        end
        rd_exp_reg <= exp_mem[cnt_reg];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            prob_reg <= prob_next;
            chan_reg <= gsm_pkg::CHAN_W'(cnt_reg);
            last_reg <= status.cnt_last;
        end
    end

    assign out_data = {1'b0, chan_reg, prob_reg};
    assign out_last = last_reg;
endmodule

/* hw/rtl/gsm_ctrl.sv */
// Controller: sequences load, max, exp and divide passes over the store.
// Depends on gsm_pkg.
module gsm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    input  logic                  m_tready,
    input  gsm_pkg::gsm_status_t  status,
    output logic                  s_tready,
    output logic                  m_tvalid,
    output gsm_pkg::gsm_cmd_t     cmd
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_MAX_RD, ST_MAX_UPD, ST_EXP_RD, ST_EXP_GO, ST_EXP_WAIT,
        ST_DIV_RD, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.load_we = 1'b1;
                    if (s_tlast) begin
                        cmd.load_end = 1'b1;
                        cmd.cnt_clr  = 1'b1;
                        state_next   = ST_MAX_RD;
                    end
                end
            end
            ST_MAX_RD: state_next = ST_MAX_UPD;
            ST_MAX_UPD: begin
                cmd.max_upd = 1'b1;
                if (status.cnt_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_EXP_RD;
                end else begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_MAX_RD;
                end
            end
            ST_EXP_RD: state_next = ST_EXP_GO;
            ST_EXP_GO: begin
                cmd.exp_start = 1'b1;
                state_next    = ST_EXP_WAIT;
            end
            ST_EXP_WAIT: begin
                if (status.exp_done) begin
                    cmd.exp_wr = 1'b1;
                    if (status.cnt_last) begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_DIV_RD;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_EXP_RD;
                    end
                end
            end
            ST_DIV_RD: state_next = ST_DIV_GO;
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (status.cnt_last) begin
                        state_next = ST_LOAD;
                    end else begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = ST_DIV_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
endmodule
